// ===== hw/rtl/sfd_pkg.sv =====
// Package for the serial frame deframer and checker.
// Frame limits, command codes, status codes and the record passed front to back.
// Used by sfd_front, sfd_queue, sfd_back, the top level and the bench.
`default_nettype none

package sfd_pkg;

	localparam int MaxFrameLength = 16;
	localparam int MinFrameLength = 5;
	localparam int LenOffset      = 3;
	localparam int BodyDepth      = MaxFrameLength - LenOffset;
	localparam int CntW           = $clog2(BodyDepth + 1);
	localparam int PayloadMax     = 9;
	localparam int StoreDepth     = PayloadMax + 1;
	localparam int StoreIdxW      = $clog2(StoreDepth);
	localparam int QueueDepth     = 2;
	localparam int QPtrW          = $clog2(QueueDepth);
	localparam int QCntW          = $clog2(QueueDepth + 1);

	localparam logic [7:0] PreambleA = 8'hAA;
	localparam logic [7:0] PreambleB = 8'h55;

	localparam logic [7:0] CmdC2 = 8'hC2;
	localparam logic [7:0] CmdC5 = 8'hC5;
	localparam logic [7:0] Cmd22 = 8'h22;

	localparam logic SideRo     = 1'b0;
	localparam logic SideFaucet = 1'b1;

	typedef logic [CntW-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_LEN_BYTE = 3'd1,
		ST_BAD_CMD      = 3'd2,
		ST_BAD_LEN      = 3'd3,
		ST_BAD_FSUM     = 3'd4,
		ST_BAD_PSUM     = 3'd5
	} status_t;

	typedef struct packed {
		logic                  bad_len_byte;
		logic [7:0]            cmd;
		logic [PayloadMax-1:0][7:0] pay;
		cnt_t                  n;
		logic [7:0]            sum;
		logic [7:0]            last;
		logic [7:0]            prev;
	} frame_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfd_rx_if.sv =====
// Receive byte channel: valid/ready handshake with one UART byte per beat.
// Depends on nothing.
`default_nettype none

interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_res_if.sv =====
// Result channel: valid/ready handshake, one checked frame status per beat.
// Depends on nothing.
`default_nettype none

interface sfd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  command_code;
	logic [3:0]  payload_count;
	logic [63:0] payload_first_eight;
	logic [7:0]  payload_ninth;

	modport source (output valid, output status, output command_code, output payload_count,
		output payload_first_eight, output payload_ninth, input ready);
	modport sink (input valid, input status, input command_code, input payload_count,
		input payload_first_eight, input payload_ninth, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfd_front.sv =====
// Front end: preamble hunt, length byte check and body capture.
// Pushes one frame record per finished frame or rejected length byte.
// Depends on sfd_pkg and sfd_rx_if.
`default_nettype none

module sfd_front (
	input  wire                 clk,
	input  wire                 arst_n,
	sfd_rx_if.sink              rx,
	output logic                push_valid,
	input  wire                 push_ready,
	output sfd_pkg::frame_rec_t push_rec
);

	typedef enum logic [1:0] {
		HUNT_AA,
		HUNT_55,
		LEN,
		BODY
	} phase_t;

	phase_t              phase_q;
	sfd_pkg::cnt_t       cnt_q;
	sfd_pkg::cnt_t       exp_q;
	logic [7:0]          sum_q;
	logic [7:0]          last_q;
	logic [7:0]          store_q [sfd_pkg::StoreDepth];
	logic                accept;
	logic                len_ok;
	logic [sfd_pkg::CntW:0] cnt_nx;
	logic                body_done;
	logic [7:0]          b;

	assign b        = rx.rx_byte;
	assign rx.ready = push_ready;
	assign accept   = rx.valid && push_ready;
	assign len_ok   = (b >= 8'(sfd_pkg::MinFrameLength)) && (b <= 8'(sfd_pkg::MaxFrameLength));
	assign cnt_nx   = {1'b0, cnt_q} + 1'b1;
	assign body_done = cnt_nx >= {1'b0, exp_q};

	always_comb begin
		push_rec = '0;
		push_valid = 1'b0;
		if (phase_q == LEN) begin
			push_valid = accept && !len_ok;
			push_rec.bad_len_byte = 1'b1;
		end else if (phase_q == BODY) begin
			push_valid = accept && body_done;
			push_rec.cmd = (cnt_q == '0) ? b : store_q[0];
			for (int i = 0; i < sfd_pkg::PayloadMax; i++) begin
				push_rec.pay[i] = (cnt_q == sfd_pkg::cnt_t'(i + 1)) ? b : store_q[i + 1];
			end
			push_rec.n    = cnt_nx[sfd_pkg::CntW-1:0];
			push_rec.sum  = sum_q + b;
			push_rec.last = b;
			push_rec.prev = last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= HUNT_AA;
			cnt_q   <= '0;
			exp_q   <= '0;
			sum_q   <= '0;
			last_q  <= '0;
		end else if (accept) begin
			case (phase_q)
				HUNT_AA: begin
					if (b == sfd_pkg::PreambleA) phase_q <= HUNT_55;
				end
				HUNT_55: begin
					if (b == sfd_pkg::PreambleB) phase_q <= LEN;
					else if (b != sfd_pkg::PreambleA) phase_q <= HUNT_AA;
				end
				LEN: begin
					if (len_ok) begin
						exp_q   <= sfd_pkg::cnt_t'(b - 8'(sfd_pkg::LenOffset));
						cnt_q   <= '0;
						sum_q   <= '0;
						phase_q <= BODY;
					end else if (b == sfd_pkg::PreambleA) begin
						phase_q <= HUNT_55;
					end else begin
						phase_q <= HUNT_AA;
					end
				end
				BODY: begin
					cnt_q  <= cnt_nx[sfd_pkg::CntW-1:0];
					sum_q  <= sum_q + b;
					last_q <= b;
					if (body_done) phase_q <= HUNT_AA;
				end
				default: phase_q <= HUNT_AA;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == BODY && cnt_q < sfd_pkg::cnt_t'(sfd_pkg::StoreDepth)) begin
			store_q[cnt_q[sfd_pkg::StoreIdxW-1:0]] <= b;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_queue.sv =====
// Two-entry queue of frame records between front and back.
// Depends on sfd_pkg.
`default_nettype none

module sfd_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  sfd_pkg::frame_rec_t push_rec,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output sfd_pkg::frame_rec_t pop_rec
);

	sfd_pkg::frame_rec_t            slot_q [sfd_pkg::QueueDepth];
	logic [sfd_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [sfd_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [sfd_pkg::QCntW-1:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = count_q != sfd_pkg::QCntW'(sfd_pkg::QueueDepth);
	assign pop_valid  = count_q != '0;
	assign pop_rec    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_rec;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_back.sv =====
// Back end: checks command, length and checksums, one record per cycle unless
// res stalls. Drives the registered result channel; uses sfd_pkg, sfd_res_if.
`default_nettype none

module sfd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sender_side,
	input  wire                 pop_valid,
	output logic                pop_ready,
	input  sfd_pkg::frame_rec_t pop_rec,
	sfd_res_if.source           res
);

	typedef enum logic [1:0] {
		PM_NONE,
		PM_LESS_FIRST,
		PM_FULL
	} pmode_t;

	logic             valid_q;
	sfd_pkg::status_t status_q;
	logic [7:0]       cmd_q;
	logic [3:0]       count_q;
	logic [63:0]      first8_q;
	logic [7:0]       ninth_q;

	sfd_pkg::status_t st;
	logic [3:0]       cnt_o;
	logic [63:0]      first8;
	logic [7:0]       ninth;
	logic             cmd_ok;
	sfd_pkg::cnt_t    want;
	pmode_t           pmode;
	logic [7:0]       ovh;
	sfd_pkg::cnt_t    net;
	sfd_pkg::cnt_t    plen;
	logic [7:0]       base;
	logic [7:0]       fsum;
	logic [7:0]       psum;
	logic             take;

	assign pop_ready = !valid_q || res.ready;
	assign take      = pop_valid && pop_ready;

	always_comb begin
		cmd_ok = 1'b1;
		want   = '0;
		pmode  = PM_NONE;
		if (sender_side == sfd_pkg::SideRo) begin
			if (pop_rec.cmd == sfd_pkg::CmdC2) begin
				want = sfd_pkg::cnt_t'(3);
				pmode = PM_FULL;
			end else if (pop_rec.cmd == sfd_pkg::CmdC5) begin
				want = sfd_pkg::cnt_t'(8);
				pmode = PM_NONE;
			end else if (pop_rec.cmd == sfd_pkg::Cmd22) begin
				want = sfd_pkg::cnt_t'(9);
				pmode = PM_LESS_FIRST;
			end else begin
				cmd_ok = 1'b0;
			end
		end else begin
			if (pop_rec.cmd == sfd_pkg::Cmd22) begin
				want = sfd_pkg::cnt_t'(8);
				pmode = PM_FULL;
			end else begin
				cmd_ok = 1'b0;
			end
		end

		ovh  = (pmode == PM_NONE) ? 8'd5 : 8'd6;
		net  = (pmode == PM_NONE) ? sfd_pkg::cnt_t'(2) : sfd_pkg::cnt_t'(3);
		plen = pop_rec.n - net;
		base = pop_rec.sum - pop_rec.cmd - pop_rec.last;
		if (pmode != PM_NONE) base = base - pop_rec.prev;
		fsum = 8'hAA + 8'h55 + ovh + 8'(plen) + pop_rec.cmd + base;
		psum = (pmode == PM_LESS_FIRST) ? (base - pop_rec.pay[0]) : base;

		for (int i = 0; i < 8; i++) begin
			first8[8*i +: 8] = (sfd_pkg::cnt_t'(i) < plen) ? pop_rec.pay[i] : 8'h00;
		end
		ninth = (plen > sfd_pkg::cnt_t'(8)) ? pop_rec.pay[8] : 8'h00;
		cnt_o = 4'(plen);

		if (pop_rec.bad_len_byte) begin
			st = sfd_pkg::ST_BAD_LEN_BYTE;
		end else if (!cmd_ok) begin
			st = sfd_pkg::ST_BAD_CMD;
		end else if (pop_rec.n < net || plen != want) begin
			st = sfd_pkg::ST_BAD_LEN;
		end else if (fsum != pop_rec.last) begin
			st = sfd_pkg::ST_BAD_FSUM;
		end else if (pmode != PM_NONE && psum != pop_rec.prev) begin
			st = sfd_pkg::ST_BAD_PSUM;
		end else begin
			st = sfd_pkg::ST_OK;
		end

		if (st == sfd_pkg::ST_BAD_LEN_BYTE || st == sfd_pkg::ST_BAD_CMD
				|| st == sfd_pkg::ST_BAD_LEN) begin
			cnt_o  = '0;
			first8 = '0;
			ninth  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= st;
			cmd_q    <= pop_rec.bad_len_byte ? 8'h00 : pop_rec.cmd;
			count_q  <= cnt_o;
			first8_q <= first8;
			ninth_q  <= ninth;
		end
	end

	assign res.valid               = valid_q;
	assign res.status              = status_q;
	assign res.command_code        = cmd_q;
	assign res.payload_count       = count_q;
	assign res.payload_first_eight = first8_q;
	assign res.payload_ninth       = ninth_q;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_deframer_checker.sv =====
// Serial frame deframer and checker, top level.
// Holds the sender side register and joins front, queue and back.
// Depends on sfd_pkg, sfd_rx_if, sfd_res_if, sfd_front, sfd_queue, sfd_back.
//
// Use: received UART bytes enter on rx, one per beat. The block hunts for the
// preamble AA 55, reads a length byte from 5 to 16 and captures the body.
// A rejected length byte yields a status beat on res; a finished frame yields
// one beat carrying status, command and payload after its checks.
// cfg_wr_en/cfg_wr_data write the sender side (0 RO unit, 1 faucet); the user
// is to write it only while idle, which the block does not enforce.
// Throughput: one byte per cycle; rx.ready drops only while the two-entry
// record queue is full, which happens when res stalls. The record of the last
// byte of a frame (or a bad length byte) enters the queue when that byte is
// accepted, and the check stage registers the result beat as it pops the record.
// Reset: arst_n clears the hunt to waiting for AA, empties the queue, drops
// res.valid and sets the sender side to the RO unit.
// A stalled res holds its beat; the front keeps taking bytes until the queue
// is full.
`default_nettype none

module serial_frame_deframer_checker (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   cfg_wr_en,
	input  wire   cfg_wr_data,
	sfd_rx_if.sink    rx,
	sfd_res_if.source res
);

	logic                side_q;
	logic                push_valid;
	logic                push_ready;
	sfd_pkg::frame_rec_t push_rec;
	logic                pop_valid;
	logic                pop_ready;
	sfd_pkg::frame_rec_t pop_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= sfd_pkg::SideRo;
		end else if (cfg_wr_en) begin
			side_q <= cfg_wr_data;
		end
	end

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	sfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sender_side (side_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_rec     (pop_rec),
		.res         (res)
	);

`ifndef SYNTHESIS
	a_bad_len_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == sfd_pkg::ST_BAD_LEN_BYTE
		|-> res.command_code == 8'h00 && res.payload_count == 4'd0)
		else $error("bad length byte status carries data");

	a_rejected_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.status == sfd_pkg::ST_BAD_CMD || res.status == sfd_pkg::ST_BAD_LEN)
		|-> res.payload_count == 4'd0 && res.payload_first_eight == 64'd0
		&& res.payload_ninth == 8'h00)
		else $error("rejected frame carries payload");

	a_ninth_needs_count: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload_ninth != 8'h00 |-> res.payload_count == 4'd9)
		else $error("ninth payload byte without nine-byte payload");

	a_push_only_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("frame record pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for serial_frame_deframer_checker: byte stream in, frame reports out.
// A built-in deframer predicts every report; bursty sender, stalling receiver, side changes.
// Depends on sfd_pkg, sfd_rx_if, sfd_res_if and the block's RTL.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfd_pkg::*;

	typedef enum logic [1:0] {HUNT_AA, HUNT_55, HUNT_LEN, HUNT_BODY} hunt_t;
	typedef enum int {FLAW_NONE, FLAW_FSUM, FLAW_PSUM} flaw_t;
	typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	localparam logic [7:0] CmdUnknown = 8'h00;

	typedef struct packed {
		status_t     status;
		logic [7:0]  cmd;
		logic [3:0]  cnt;
		logic [63:0] first8;
		logic [7:0]  ninth;
	} frame_report_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	sfd_rx_if  rx ();
	sfd_res_if res ();

	serial_frame_deframer_checker u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx),
		.res         (res)
	);

	// deframer mirror
	hunt_t      m_hunt = HUNT_AA;
	logic [7:0] m_need = '0;
	logic [7:0] m_got  = '0;
	logic [7:0] m_sum  = '0;
	logic [7:0] m_body [BodyDepth];
	logic       m_side = SideRo;

	frame_report_t frame_reports_q [$];
	logic [7:0]    rx_pending [$];
	int            gen_count = 0;
	logic          gen_side  = SideRo;
	int            err_cnt   = 0;

	function automatic bit deframe_byte(input logic [7:0] b, output frame_report_t r);
		logic [7:0] cmd, base, fsum, psum;
		int         want, n, net, plen;
		bit         has_psum, skip_first;
		r = '0;
		has_psum = 1'b0;
		skip_first = 1'b0;
		want = 0;
		case (m_hunt)
			HUNT_AA: begin
				if (b == PreambleA)
					m_hunt = HUNT_55;
				return 1'b0;
			end
			HUNT_55: begin
				m_hunt = (b == PreambleB) ? HUNT_LEN : (b == PreambleA) ? HUNT_55 : HUNT_AA;
				return 1'b0;
			end
			HUNT_LEN: begin
				if (b >= MinFrameLength && b <= MaxFrameLength) begin
					m_need = 8'(b - LenOffset);
					m_got  = '0;
					m_sum  = '0;
					m_hunt = HUNT_BODY;
					return 1'b0;
				end
				m_hunt = (b == PreambleA) ? HUNT_55 : HUNT_AA;
				r.status = ST_BAD_LEN_BYTE;
				return 1'b1;
			end
			default: begin
				m_body[m_got] = b;
				m_got = m_got + 8'd1;
				m_sum = m_sum + b;
				if (m_got < m_need)
					return 1'b0;
				m_hunt = HUNT_AA;
			end
		endcase

		n = int'(m_got);
		cmd = m_body[0];
		r.cmd = cmd;
		if (m_side == SideRo && cmd == CmdC2) begin
			want = 3;
			has_psum = 1'b1;
		end else if (m_side == SideRo && cmd == CmdC5) begin
			want = 8;
		end else if (m_side == SideRo && cmd == Cmd22) begin
			want = 9;
			has_psum = 1'b1;
			skip_first = 1'b1;
		end else if (m_side == SideFaucet && cmd == Cmd22) begin
			want = 8;
			has_psum = 1'b1;
		end else begin
			r.status = ST_BAD_CMD;
			return 1'b1;
		end

		net = has_psum ? 3 : 2;
		if (net > n || n - net != want) begin
			r.status = ST_BAD_LEN;
			return 1'b1;
		end
		plen = n - net;

		base = m_sum - cmd - m_body[n-1];
		if (has_psum)
			base = base - m_body[n-2];
		for (int i = 0; i < plen && i < 8; i++)
			r.first8[8*i +: 8] = m_body[1+i];
		if (plen > 8)
			r.ninth = m_body[9];
		r.cnt = 4'(plen);

		fsum = PreambleA + PreambleB + 8'(net + LenOffset + plen) + cmd + base;
		psum = skip_first ? base - m_body[1] : base;
		if (fsum != m_body[n-1])
			r.status = ST_BAD_FSUM;
		else if (has_psum && psum != m_body[n-2])
			r.status = ST_BAD_PSUM;
		else
			r.status = ST_OK;
		return 1'b1;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		rx_pending.push_back(b);
		gen_count++;
	endtask

	task automatic queue_frame(input logic [7:0] cmd, input int plen, input flaw_t flaw,
		input fill_t fill);
		logic [7:0] b, first, pay_sum, fsum;
		int         ovh;
		ovh = (cmd == CmdC5) ? 5 : 6;
		pay_sum = '0;
		first = '0;
		push_byte(PreambleA);
		push_byte(PreambleB);
		push_byte(8'(plen + ovh));
		push_byte(cmd);
		for (int i = 0; i < plen; i++) begin
			b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
			if (i == 0)
				first = b;
			pay_sum = pay_sum + b;
			push_byte(b);
		end
		fsum = PreambleA + PreambleB + 8'(ovh + plen) + cmd + pay_sum;
		if (ovh == 6) begin
			b = (cmd == Cmd22 && gen_side == SideRo) ? pay_sum - first : pay_sum;
			if (flaw == FLAW_PSUM)
				b = b + 8'($urandom_range(1, 255));
			push_byte(b);
		end
		if (flaw == FLAW_FSUM)
			fsum = fsum + 8'($urandom_range(1, 255));
		push_byte(fsum);
	endtask

	task automatic queue_raw(input int len, input logic [7:0] cmd);
		push_byte(PreambleA);
		push_byte(PreambleB);
		push_byte(8'(len));
		push_byte(cmd);
		for (int i = 0; i < len - 4; i++)
			push_byte(8'($urandom));
	endtask

	task automatic queue_bad_len(input logic [7:0] b);
		push_byte(PreambleA);
		push_byte(PreambleB);
		push_byte(b);
	endtask

	task automatic queue_noise;
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			case ($urandom_range(0, 3))
				0: push_byte(PreambleA);
				1: push_byte(PreambleB);
				default: push_byte(8'($urandom));
			endcase
	endtask

	task automatic wait_drained;
		do @(posedge clk);
		while (rx_pending.size() != 0 || rx.valid || frame_reports_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_side(input logic side);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= side;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		m_side   = side;
		gen_side = side;
	endtask

	task automatic note_mismatch(input string what, input frame_report_t want,
		input frame_report_t seen);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: exp/act status %0d/%0d cmd %h/%h cnt %0d/%0d",
				$realtime, what, want.status, seen.status, want.cmd, seen.cmd,
				want.cnt, seen.cnt,
				"\n    first8 %h/%h ninth %h/%h",
				want.first8, seen.first8, want.ninth, seen.ninth);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// byte driver: bursts with random gaps
	int            gap_left   = 0;
	int            burst_left = 0;
	frame_report_t next_report;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx.valid && rx.ready)
				if (deframe_byte(rx.rx_byte, next_report))
					frame_reports_q.push_back(next_report);
			if (rx.valid && !rx.ready) begin
				// hold the beat
			end else if (gap_left > 0) begin
				rx.valid <= 1'b0;
				gap_left--;
			end else if (rx_pending.size() != 0) begin
				rx.valid   <= 1'b1;
				rx.rx_byte <= rx_pending.pop_front();
				if (burst_left == 0) begin
					if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 20);
						gap_left   = $urandom_range(1, 8);
					end
				end else begin
					burst_left--;
				end
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// report monitor with its own stall pattern
	int            stall_mode = 0;
	int            mode_left  = 0;
	int            tick       = 0;
	frame_report_t seen_report;
	frame_report_t want_report;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				seen_report.status = status_t'(res.status);
				seen_report.cmd    = res.command_code;
				seen_report.cnt    = res.payload_count;
				seen_report.first8 = res.payload_first_eight;
				seen_report.ninth  = res.payload_ninth;
				if (frame_reports_q.size() == 0) begin
					note_mismatch("unpredicted report", '0, seen_report);
				end else begin
					want_report = frame_reports_q.pop_front();
					if (seen_report.status !== want_report.status
						|| seen_report.cmd !== want_report.cmd
						|| seen_report.cnt !== want_report.cnt
						|| seen_report.first8 !== want_report.first8
						|| seen_report.ninth !== want_report.ninth)
						note_mismatch("report mismatch", want_report, seen_report);
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			tick++;
			case (stall_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= 1'($urandom_range(0, 1));
				2: res.ready <= (tick % 4 == 0);
				default: res.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	initial begin
		int         pick, f, k, want, plen, b, phase_end;
		logic [7:0] cmd;
		flaw_t      flaw;
		fill_t      fill;

		rx.valid    = 1'b0;
		rx.rx_byte  = '0;
		res.ready   = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		arst_n      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// RO side, straight out of reset
		queue_frame(CmdC2, 3, FLAW_NONE, FILL_RAND);
		queue_frame(CmdC5, 8, FLAW_NONE, FILL_ZERO);
		queue_frame(Cmd22, 9, FLAW_NONE, FILL_ONES);
		queue_frame(CmdC2, 3, FLAW_FSUM, FILL_RAND);
		queue_frame(CmdC2, 3, FLAW_PSUM, FILL_RAND);
		queue_frame(Cmd22, 9, FLAW_PSUM, FILL_RAND);
		queue_frame(CmdC5, 7, FLAW_NONE, FILL_RAND);
		queue_raw(MinFrameLength, Cmd22);
		queue_raw(MaxFrameLength, CmdC2);
		queue_raw(8, CmdUnknown);
		queue_bad_len(8'(MinFrameLength - 1));
		queue_bad_len(8'(MaxFrameLength + 1));
		queue_bad_len(8'hFF);
		queue_bad_len(8'h00);
		queue_bad_len(PreambleA);
		queue_frame(Cmd22, 9, FLAW_NONE, FILL_RAND);
		push_byte(PreambleA);
		push_byte(PreambleA);
		queue_frame(CmdC5, 8, FLAW_NONE, FILL_ONES);
		wait_drained();

		write_side(SideFaucet);
		queue_frame(Cmd22, 8, FLAW_NONE, FILL_RAND);
		queue_frame(Cmd22, 8, FLAW_PSUM, FILL_ONES);
		queue_frame(Cmd22, 8, FLAW_FSUM, FILL_ZERO);
		queue_frame(CmdC2, 3, FLAW_NONE, FILL_RAND);
		queue_frame(CmdC5, 8, FLAW_NONE, FILL_RAND);
		queue_frame(Cmd22, 9, FLAW_NONE, FILL_RAND);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			write_side((ph % 2 == 0) ? SideRo : SideFaucet);
			phase_end = gen_count + 185;
			while (gen_count < phase_end) begin
				pick = $urandom_range(0, 99);
				if (gen_side == SideRo) begin
					k    = $urandom_range(0, 2);
					cmd  = (k == 0) ? CmdC2 : (k == 1) ? CmdC5 : Cmd22;
					want = (k == 0) ? 3 : (k == 1) ? 8 : 9;
				end else begin
					cmd  = Cmd22;
					want = 8;
				end
				if (pick < 62) begin
					f = $urandom_range(0, 99);
					flaw = (f < 15) ? FLAW_FSUM : (f < 27 && cmd != CmdC5) ? FLAW_PSUM : FLAW_NONE;
					f = $urandom_range(0, 19);
					fill = (f == 0) ? FILL_ZERO : (f == 1) ? FILL_ONES : FILL_RAND;
					queue_frame(cmd, want, flaw, fill);
				end else if (pick < 70) begin
					do plen = $urandom_range(0, MaxFrameLength - ((cmd == CmdC5) ? 5 : 6));
					while (plen == want);
					queue_frame(cmd, plen, FLAW_NONE, FILL_RAND);
				end else if (pick < 78) begin
					f = $urandom_range(0, 3);
					queue_raw($urandom_range(MinFrameLength, MaxFrameLength),
						(f == 0) ? 8'($urandom) : (f == 1) ? CmdC2 : (f == 2) ? CmdC5 : Cmd22);
				end else if (pick < 87) begin
					do b = $urandom_range(0, 255);
					while (b >= MinFrameLength && b <= MaxFrameLength);
					queue_bad_len(8'(b));
				end else begin
					queue_noise();
				end
			end
			// flush any half-read body before the side changes
			for (int i = 0; i < BodyDepth; i++)
				push_byte(8'h00);
			wait_drained();
		end

		if (err_cnt == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_rx_if.sv
hw/rtl/sfd_res_if.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/serial_frame_deframer_checker.sv
tb/tb.sv
